@@ sv/voxel_face_emitter_with_occlusion_macros.svh @@
// assertion macros shared by the checker
`ifndef VOXEL_FACE_EMITTER_WITH_OCCLUSION_MACROS_SVH
`define VOXEL_FACE_EMITTER_WITH_OCCLUSION_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define VFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, quiet while reset is held
`define VFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ sv/vfe_pkg.sv @@
package vfe_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // depth of the queue between classifier and emitter
    localparam int QUEUE_DEPTH = 2;

    // face codes, in emission order
    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_LEFT   = 3'd1;
    localparam logic [2:0] FACE_BOTTOM = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;
    localparam int NUM_FACES = 6;

    // corner codes
    localparam logic [1:0] CORNER_LB = 2'd0;
    localparam logic [1:0] CORNER_RB = 2'd1;
    localparam logic [1:0] CORNER_RT = 2'd2;
    localparam logic [1:0] CORNER_LT = 2'd3;

    // shade codes
    localparam logic [1:0] SHADE_FULL   = 2'd0;
    localparam logic [1:0] SHADE_OCC    = 2'd1;
    localparam logic [1:0] SHADE_BOTTOM = 2'd2;

    // occlusion rule selectors; all but RULE_DIM are also bit positions in the occlusion flags
    localparam logic [2:0] RULE_LOW = 3'd0;
    localparam logic [2:0] RULE_FL  = 3'd1;
    localparam logic [2:0] RULE_FR  = 3'd2;
    localparam logic [2:0] RULE_BL  = 3'd3;
    localparam logic [2:0] RULE_BR  = 3'd4;
    localparam logic [2:0] RULE_DIM = 3'd5;
    localparam int NUM_OCC = 5;

    typedef struct packed {
        logic       dx;
        logic       dy;
        logic       dz;
        logic [2:0] rule;
    } t_corner;

    function automatic t_corner mk_corner(input logic dx, input logic dy, input logic dz,
                                          input logic [2:0] rule);
        t_corner r;
        r.dx   = dx;
        r.dy   = dy;
        r.dz   = dz;
        r.rule = rule;
        return r;
    endfunction

    // fixed corner offsets and shade rule for each face and corner
    function automatic t_corner corner_desc(input logic [2:0] f, input logic [1:0] c);
        t_corner r;
        case ({f, c})
            {FACE_FRONT,  CORNER_LB}: r = mk_corner(1'b0, 1'b0, 1'b0, RULE_LOW);
            {FACE_FRONT,  CORNER_RB}: r = mk_corner(1'b1, 1'b0, 1'b0, RULE_LOW);
            {FACE_FRONT,  CORNER_RT}: r = mk_corner(1'b1, 1'b1, 1'b0, RULE_FR);
            {FACE_FRONT,  CORNER_LT}: r = mk_corner(1'b0, 1'b1, 1'b0, RULE_FL);
            {FACE_LEFT,   CORNER_LB}: r = mk_corner(1'b0, 1'b0, 1'b1, RULE_LOW);
            {FACE_LEFT,   CORNER_RB}: r = mk_corner(1'b0, 1'b0, 1'b0, RULE_LOW);
            {FACE_LEFT,   CORNER_RT}: r = mk_corner(1'b0, 1'b1, 1'b0, RULE_FL);
            {FACE_LEFT,   CORNER_LT}: r = mk_corner(1'b0, 1'b1, 1'b1, RULE_BL);
            {FACE_BOTTOM, CORNER_LB}: r = mk_corner(1'b0, 1'b0, 1'b1, RULE_DIM);
            {FACE_BOTTOM, CORNER_RB}: r = mk_corner(1'b1, 1'b0, 1'b1, RULE_DIM);
            {FACE_BOTTOM, CORNER_RT}: r = mk_corner(1'b1, 1'b0, 1'b0, RULE_DIM);
            {FACE_BOTTOM, CORNER_LT}: r = mk_corner(1'b0, 1'b0, 1'b0, RULE_DIM);
            {FACE_RIGHT,  CORNER_LB}: r = mk_corner(1'b1, 1'b0, 1'b0, RULE_LOW);
            {FACE_RIGHT,  CORNER_RB}: r = mk_corner(1'b1, 1'b0, 1'b1, RULE_LOW);
            {FACE_RIGHT,  CORNER_RT}: r = mk_corner(1'b1, 1'b1, 1'b1, RULE_BR);
            {FACE_RIGHT,  CORNER_LT}: r = mk_corner(1'b1, 1'b1, 1'b0, RULE_FR);
            {FACE_TOP,    CORNER_LB}: r = mk_corner(1'b0, 1'b1, 1'b0, RULE_FL);
            {FACE_TOP,    CORNER_RB}: r = mk_corner(1'b1, 1'b1, 1'b0, RULE_FR);
            {FACE_TOP,    CORNER_RT}: r = mk_corner(1'b1, 1'b1, 1'b1, RULE_BR);
            {FACE_TOP,    CORNER_LT}: r = mk_corner(1'b0, 1'b1, 1'b1, RULE_BL);
            {FACE_BACK,   CORNER_LB}: r = mk_corner(1'b1, 1'b0, 1'b1, RULE_LOW);
            {FACE_BACK,   CORNER_RB}: r = mk_corner(1'b0, 1'b0, 1'b1, RULE_LOW);
            {FACE_BACK,   CORNER_RT}: r = mk_corner(1'b0, 1'b1, 1'b1, RULE_BL);
            {FACE_BACK,   CORNER_LT}: r = mk_corner(1'b1, 1'b1, 1'b1, RULE_BR);
            default:                  r = mk_corner(1'b0, 1'b0, 1'b0, RULE_DIM);
        endcase
        return r;
    endfunction

endpackage

@@ sv/vfe_channels.sv @@
// block item channel
interface vfe_in_if #(
    parameter int COORD_BITS = vfe_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic        [7:0]            pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic        [5:0]            face_neighbors;
    logic        [7:0]            upper_neighbors;

    modport source (output valid, pos_x, pos_y, pos_z, face_neighbors, upper_neighbors,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, face_neighbors, upper_neighbors,
                    output ready);
endinterface

// vertex item channel
interface vfe_out_if #(
    parameter int COORD_BITS = vfe_pkg::COORD_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] vert_x;
    logic        [8:0]          vert_y;
    logic signed [COORD_BITS:0] vert_z;
    logic        [2:0]          face;
    logic        [1:0]          corner;
    logic        [1:0]          shade;
    logic                       last;

    modport source (output valid, vert_x, vert_y, vert_z, face, corner, shade, last,
                    input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, face, corner, shade, last,
                    output ready);
endinterface

@@ sv/vfe_classify.sv @@
module vfe_classify #(
    parameter int COORD_BITS = vfe_pkg::COORD_BITS_DEF,
    parameter int WIDTH      = 2 * COORD_BITS + 8 + vfe_pkg::NUM_FACES + vfe_pkg::NUM_OCC
) (
    vfe_in_if.sink         i_item,
    input  logic           i_q_ready,
    output logic           o_q_push,
    output logic [WIDTH-1:0] o_q_data
);

    logic [vfe_pkg::NUM_FACES-1:0] w_mask;
    logic [vfe_pkg::NUM_OCC-1:0]   w_occ;
    logic [7:0]                    w_un;

    assign w_un = i_item.upper_neighbors;

    // visible faces: neighbor not solid, no bottom face at ground level
    always_comb begin
        w_mask = ~i_item.face_neighbors;
        if (i_item.pos_y == 8'd0) begin
            w_mask[vfe_pkg::FACE_BOTTOM] = 1'b0;
        end
    end

    // occlusion flag per shade rule
    always_comb begin
        w_occ = '0;
        w_occ[vfe_pkg::RULE_LOW] = i_item.face_neighbors[vfe_pkg::FACE_BOTTOM];
        w_occ[vfe_pkg::RULE_FL]  = w_un[0] | w_un[2] | w_un[4];
        w_occ[vfe_pkg::RULE_FR]  = w_un[0] | w_un[3] | w_un[5];
        w_occ[vfe_pkg::RULE_BL]  = w_un[1] | w_un[2] | w_un[6];
        w_occ[vfe_pkg::RULE_BR]  = w_un[1] | w_un[3] | w_un[7];
    end

    // a fully hidden block is taken and dropped
    assign i_item.ready = i_q_ready;
    assign o_q_push     = i_item.valid && i_q_ready && (w_mask != '0);
    assign o_q_data     = {i_item.pos_x, i_item.pos_y, i_item.pos_z, w_mask, w_occ};

endmodule

@@ sv/vfe_queue.sv @@
module vfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vfe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_ready   = (r_cnt != CW'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/vfe_emit.sv @@
module vfe_emit #(
    parameter int COORD_BITS = vfe_pkg::COORD_BITS_DEF,
    parameter int WIDTH      = 2 * COORD_BITS + 8 + vfe_pkg::NUM_FACES + vfe_pkg::NUM_OCC
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [WIDTH-1:0] i_q_data,
    output logic             o_q_pop,
    vfe_out_if.source        o_vert
);

    localparam int NF = vfe_pkg::NUM_FACES;
    localparam int NO = vfe_pkg::NUM_OCC;

    // item being emitted
    logic                         r_busy;
    logic signed [COORD_BITS-1:0] r_pos_x, r_pos_z;
    logic        [7:0]            r_pos_y;
    logic        [NF-1:0]         r_mask;
    logic        [NO-1:0]         r_occ;
    logic        [1:0]            r_corner;

    // output register
    logic                       r_ov;
    logic signed [COORD_BITS:0] r_vx, r_vz;
    logic        [8:0]          r_vy;
    logic        [2:0]          r_face;
    logic        [1:0]          r_vcorner, r_shade;
    logic                       r_last;

    logic                   w_adv, w_quad_end, w_item_end, w_pop;
    logic [2:0]             w_face;
    logic [NF-1:0]          w_face_bit, w_mask_left;
    vfe_pkg::t_corner       w_cd;
    logic [1:0]             w_shade;

    // lowest remaining face
    always_comb begin
        w_face = vfe_pkg::FACE_FRONT;
        for (int i = NF - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_face = 3'(i);
            end
        end
    end

    assign w_face_bit  = NF'(1) << w_face;
    assign w_mask_left = r_mask & ~w_face_bit;
    assign w_quad_end  = (r_corner == vfe_pkg::CORNER_LT);
    assign w_item_end  = w_quad_end && (w_mask_left == '0);
    assign w_adv       = r_busy && (!r_ov || o_vert.ready);
    assign w_pop       = i_q_valid && (!r_busy || (w_adv && w_item_end));
    assign o_q_pop     = w_pop;

    // corner offsets and shade
    assign w_cd = vfe_pkg::corner_desc(w_face, r_corner);
    always_comb begin
        if (w_cd.rule == vfe_pkg::RULE_DIM) begin
            w_shade = vfe_pkg::SHADE_BOTTOM;
        end else if (r_occ[w_cd.rule]) begin
            w_shade = vfe_pkg::SHADE_OCC;
        end else begin
            w_shade = vfe_pkg::SHADE_FULL;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_corner <= vfe_pkg::CORNER_LB;
            r_ov     <= 1'b0;
        end else begin
            if (w_pop) begin
                r_busy   <= 1'b1;
                r_corner <= vfe_pkg::CORNER_LB;
            end else if (w_adv) begin
                r_corner <= r_corner + 2'd1;
                if (w_item_end) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (o_vert.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // item payload and remaining faces
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            {r_pos_x, r_pos_y, r_pos_z, r_mask, r_occ} <= i_q_data;
        end else if (w_adv && w_quad_end) begin
            r_mask <= w_mask_left;
        end
    end

    // vertex output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vx      <= {r_pos_x[COORD_BITS-1], r_pos_x} + (COORD_BITS + 1)'(w_cd.dx);
            r_vy      <= {1'b0, r_pos_y} + 9'(w_cd.dy);
            r_vz      <= {r_pos_z[COORD_BITS-1], r_pos_z} + (COORD_BITS + 1)'(w_cd.dz);
            r_face    <= w_face;
            r_vcorner <= r_corner;
            r_shade   <= w_shade;
            r_last    <= w_item_end;
        end
    end

    assign o_vert.valid  = r_ov;
    assign o_vert.vert_x = r_vx;
    assign o_vert.vert_y = r_vy;
    assign o_vert.vert_z = r_vz;
    assign o_vert.face   = r_face;
    assign o_vert.corner = r_vcorner;
    assign o_vert.shade  = r_shade;
    assign o_vert.last   = r_last;

endmodule

@@ sv/voxel_face_emitter_with_occlusion.sv @@
// Voxel face emitter: each block item (position plus solid-neighbor flags) yields one quad of
// four vertex items for every visible face, in the order front, left, bottom, right, top,
// back, with last set on the final vertex; a fully hidden block yields nothing. The vertex
// emitter puts out one vertex per cycle unless the receiver holds ready low, and sustained
// throughput is one vertex per cycle set by that single output register. A two-entry
// queue between the classifier and the emitter lets new blocks be taken while the previous
// one is still being emitted; when the emitter is free, a taken block passes through the
// queue and the emitter's item registers before its first vertex leaves the output register.
module voxel_face_emitter_with_occlusion #(
    parameter int COORD_BITS = vfe_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfe_in_if.sink    i_item,
    vfe_out_if.source o_vert
);

    localparam int WIDTH = 2 * COORD_BITS + 8 + vfe_pkg::NUM_FACES + vfe_pkg::NUM_OCC;

    logic             w_push, w_q_ready, w_pop, w_q_valid;
    logic [WIDTH-1:0] w_push_data, w_pop_data;

    // classifier
    vfe_classify #(.COORD_BITS(COORD_BITS), .WIDTH(WIDTH)) u_classify (
        .i_item    (i_item),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_push),
        .o_q_data  (w_push_data)
    );

    // decoupling queue
    vfe_queue #(.WIDTH(WIDTH), .DEPTH(vfe_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    // vertex emitter
    vfe_emit #(.COORD_BITS(COORD_BITS), .WIDTH(WIDTH)) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_pop_data),
        .o_q_pop   (w_pop),
        .o_vert    (o_vert)
    );

endmodule

@@ sv/vfe_checker.sv @@
`include "voxel_face_emitter_with_occlusion_macros.svh"

module vfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_face,
    input logic [1:0] i_out_corner,
    input logic       i_out_last
);

    // a stalled vertex keeps its place in the quad
    `VFE_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_corner) && $stable(i_out_face))

    // last only closes a quad
    `VFE_ASSERT_IMP(a_last_corner, i_clk, i_rst_n, i_out_valid && i_out_last, i_out_corner == vfe_pkg::CORNER_LT)

    // a quad runs without gaps
    `VFE_ASSERT_NXT(a_quad_dense, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_out_corner != vfe_pkg::CORNER_LT), i_out_valid && (i_out_face == $past(i_out_face)))

    // corners step by one within a quad
    `VFE_ASSERT_NXT(a_corner_step, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_out_corner != vfe_pkg::CORNER_LT), i_out_corner == ($past(i_out_corner) + 2'd1))

endmodule

bind voxel_face_emitter_with_occlusion vfe_checker u_vfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_vert.valid),
    .i_out_ready  (o_vert.ready),
    .i_out_face   (o_vert.face),
    .i_out_corner (o_vert.corner),
    .i_out_last   (o_vert.last)
);

@@ tb/voxel_face_emitter_with_occlusion_test.sv @@
module voxel_face_emitter_with_occlusion_test;

    localparam int CB             = vfe_pkg::COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_TAIL     = 20;
    localparam int MAX_REPORTS    = 10;

    // corner offsets {dx, dy, dz}, indexed face * 4 + corner
    localparam logic [2:0] CUBE_OFFS [24] = '{
        3'b000, 3'b100, 3'b110, 3'b010,   // front
        3'b001, 3'b000, 3'b010, 3'b011,   // left
        3'b001, 3'b101, 3'b100, 3'b000,   // bottom
        3'b100, 3'b101, 3'b111, 3'b110,   // right
        3'b010, 3'b110, 3'b111, 3'b011,   // top
        3'b101, 3'b001, 3'b011, 3'b111    // back
    };

    // occlusion rule per corner, same indexing
    localparam logic [2:0] VERT_RULE [24] = '{
        vfe_pkg::RULE_LOW, vfe_pkg::RULE_LOW, vfe_pkg::RULE_FR,  vfe_pkg::RULE_FL,
        vfe_pkg::RULE_LOW, vfe_pkg::RULE_LOW, vfe_pkg::RULE_FL,  vfe_pkg::RULE_BL,
        vfe_pkg::RULE_DIM, vfe_pkg::RULE_DIM, vfe_pkg::RULE_DIM, vfe_pkg::RULE_DIM,
        vfe_pkg::RULE_LOW, vfe_pkg::RULE_LOW, vfe_pkg::RULE_BR,  vfe_pkg::RULE_FR,
        vfe_pkg::RULE_FL,  vfe_pkg::RULE_FR,  vfe_pkg::RULE_BR,  vfe_pkg::RULE_BL,
        vfe_pkg::RULE_LOW, vfe_pkg::RULE_LOW, vfe_pkg::RULE_BL,  vfe_pkg::RULE_BR
    };

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic        [7:0]    y;
        logic signed [CB-1:0] z;
        logic        [5:0]    fn;
        logic        [7:0]    un;
    } t_block;

    typedef struct packed {
        logic signed [CB:0] x;
        logic        [8:0]  y;
        logic signed [CB:0] z;
        logic        [2:0]  face;
        logic        [1:0]  corner;
        logic        [1:0]  shade;
        logic               last;
    } t_vertex;

    logic clk;
    logic rst_n;

    vfe_in_if  #(.COORD_BITS(CB)) blk_ch ();
    vfe_out_if #(.COORD_BITS(CB)) vert_ch ();

    voxel_face_emitter_with_occlusion #(.COORD_BITS(CB)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (blk_ch.sink),
        .o_vert  (vert_ch.source)
    );

    t_block  pending_blocks [$];
    t_vertex expected_verts [$];
    t_block  sent_block;

    bit idle_on;
    bit long_hold_req;
    int send_gap;
    int recv_hold;
    bit nxt_valid;
    bit nxt_ready;
    int idle_cycles;

    int blocks_taken;
    int hidden_blocks;
    int ground_blocks;
    int verts_checked;
    int mismatches;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // face visible unless its neighbor is solid; no bottom face at ground level
    function automatic bit face_shown(input t_block b, input int f);
        if (b.fn[f])
            return 1'b0;
        if (f == vfe_pkg::FACE_BOTTOM && b.y == 8'd0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [1:0] vertex_shade(input logic [2:0] rule, input logic [5:0] fn,
                                                input logic [7:0] un);
        logic hit;
        case (rule)
            vfe_pkg::RULE_LOW: hit = fn[2];
            vfe_pkg::RULE_FL:  hit = un[0] | un[2] | un[4];
            vfe_pkg::RULE_FR:  hit = un[0] | un[3] | un[5];
            vfe_pkg::RULE_BL:  hit = un[1] | un[2] | un[6];
            vfe_pkg::RULE_BR:  hit = un[1] | un[3] | un[7];
            default:           return vfe_pkg::SHADE_BOTTOM;
        endcase
        return hit ? vfe_pkg::SHADE_OCC : vfe_pkg::SHADE_FULL;
    endfunction

    // expected vertex items of one block, appended in emission order
    function automatic void build_quads(input t_block b);
        t_vertex    v;
        logic [2:0] off;
        int         total;
        int         emitted;
        total   = 0;
        emitted = 0;
        for (int f = 0; f < vfe_pkg::NUM_FACES; f++)
            if (face_shown(b, f))
                total += 4;
        if (total == 0)
            hidden_blocks++;
        if (b.y == 8'd0)
            ground_blocks++;
        for (int f = 0; f < vfe_pkg::NUM_FACES; f++) begin
            if (!face_shown(b, f))
                continue;
            for (int c = 0; c < 4; c++) begin
                off      = CUBE_OFFS[f * 4 + c];
                v.x      = {b.x[CB-1], b.x} + (CB+1)'(off[2]);
                v.y      = {1'b0, b.y} + 9'(off[1]);
                v.z      = {b.z[CB-1], b.z} + (CB+1)'(off[0]);
                v.face   = 3'(f);
                v.corner = 2'(c);
                v.shade  = vertex_shade(VERT_RULE[f * 4 + c], b.fn, b.un);
                emitted++;
                v.last   = (emitted == total);
                expected_verts.push_back(v);
            end
        end
    endfunction

    function automatic t_block mk_block(input int x, input int y, input int z,
                                        input int fn, input int un);
        t_block b;
        b.x  = CB'(x);
        b.y  = 8'(y);
        b.z  = CB'(z);
        b.fn = 6'(fn);
        b.un = 8'(un);
        return b;
    endfunction

    // random coordinate with extra weight on the extremes
    function automatic logic [CB-1:0] random_coord();
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(CB-1){1'b1}}};
            1:       return {1'b1, {(CB-1){1'b0}}};
            2:       return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic t_block random_block();
        t_block b;
        b.x = random_coord();
        b.z = random_coord();
        case ($urandom_range(0, 15))
            0:       b.y = 8'd0;
            1:       b.y = 8'd255;
            default: b.y = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       b.fn = 6'h3F;
            1:       b.fn = 6'h00;
            default: b.fn = 6'($urandom);
        endcase
        b.un = 8'($urandom);
        return b;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit same_vertex(input t_vertex a, input t_vertex b);
        return a.x === b.x && a.y === b.y && a.z === b.z && a.face === b.face &&
               a.corner === b.corner && a.shade === b.shade && a.last === b.last;
    endfunction

    // block item driver
    always @(posedge clk) begin
        if (!rst_n) begin
            blk_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            nxt_valid = blk_ch.valid;
            if (blk_ch.valid && blk_ch.ready) begin
                build_quads(sent_block);
                blocks_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_blocks.size() > 0) begin
                    sent_block = pending_blocks.pop_front();
                    blk_ch.pos_x           <= sent_block.x;
                    blk_ch.pos_y           <= sent_block.y;
                    blk_ch.pos_z           <= sent_block.z;
                    blk_ch.face_neighbors  <= sent_block.fn;
                    blk_ch.upper_neighbors <= sent_block.un;
                    nxt_valid = 1'b1;
                    send_gap  = pick_gap();
                end
            end
            blk_ch.valid <= nxt_valid;
        end
    end

    // vertex item monitor and back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            vert_ch.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (vert_ch.valid && vert_ch.ready) begin
                if (expected_verts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected vertex: x=%0d y=%0d z=%0d face=%0d corner=%0d",
                                 vert_ch.vert_x, vert_ch.vert_y, vert_ch.vert_z,
                                 vert_ch.face, vert_ch.corner);
                end else begin
                    t_vertex want;
                    t_vertex got;
                    want = expected_verts.pop_front();
                    got  = '{vert_ch.vert_x, vert_ch.vert_y, vert_ch.vert_z, vert_ch.face,
                             vert_ch.corner, vert_ch.shade, vert_ch.last};
                    verts_checked++;
                    if (!same_vertex(want, got)) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("vertex mismatch: exp x=%0d y=%0d z=%0d f=%0d c=%0d s=%0d l=%0d",
                                     want.x, want.y, want.z, want.face, want.corner,
                                     want.shade, want.last);
                            $display("                 got x=%0d y=%0d z=%0d f=%0d c=%0d s=%0d l=%0d",
                                     got.x, got.y, got.z, got.face, got.corner,
                                     got.shade, got.last);
                        end
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                nxt_ready = 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                recv_hold = LONG_HOLD - 1;
                nxt_ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                recv_hold = pick_gap();
                nxt_ready = (recv_hold == 0);
                if (recv_hold > 0)
                    recv_hold--;
            end else begin
                nxt_ready = 1'b1;
            end
            vert_ch.ready <= nxt_ready;
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (blk_ch.valid && blk_ch.ready) || (vert_ch.valid && vert_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("voxel_face_emitter_with_occlusion_test: errors");
                $finish;
            end
        end
    end

    // sender idle and all vertices back
    task automatic wait_drained();
        while (pending_blocks.size() > 0 || blk_ch.valid)
            @(posedge clk);
        while (expected_verts.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    initial begin
        rst_n                  = 1'b0;
        idle_on                = 1'b1;
        long_hold_req          = 1'b0;
        blk_ch.valid           = 1'b0;
        blk_ch.pos_x           = '0;
        blk_ch.pos_y           = '0;
        blk_ch.pos_z           = '0;
        blk_ch.face_neighbors  = '0;
        blk_ch.upper_neighbors = '0;
        vert_ch.ready          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fully hidden, ground level, open cube, coordinate extremes
        pending_blocks.push_back(mk_block(5, 10, -7, 'h3F, 'h00));
        pending_blocks.push_back(mk_block(0, 0, 0, 'h00, 'h00));
        pending_blocks.push_back(mk_block(3, 1, 4, 'h00, 'h00));
        pending_blocks.push_back(mk_block(32767, 255, 32767, 'h00, 'hFF));
        pending_blocks.push_back(mk_block(-32768, 0, -32768, 'h00, 'hFF));
        // only the bottom open: nothing at ground level, four dim vertices above it
        pending_blocks.push_back(mk_block(1, 0, 1, 'h3B, 'h00));
        pending_blocks.push_back(mk_block(-1, 5, -1, 'h3B, 'h00));
        // one open face at a time, with solid ground below; the bottom face stays closed by it
        for (int f = 0; f < vfe_pkg::NUM_FACES; f++)
            pending_blocks.push_back(mk_block(f * 100, 7, -f * 100,
                                              'h3F & ~(1 << f) | 'h04, $urandom));
        // solid block below shades the lower side corners
        pending_blocks.push_back(mk_block(-20, 40, 20, 'h04, 'h00));
        // each upper neighbor alone
        for (int k = 0; k < 8; k++)
            pending_blocks.push_back(mk_block(k, 3, k, 'h00, 1 << k));
        wait_drained();

        // random with idling on both sides
        repeat (60) pending_blocks.push_back(random_block());
        wait_drained();

        // receiver stalls for a long stretch while blocks keep coming
        long_hold_req = 1'b1;
        repeat (30) pending_blocks.push_back(random_block());
        wait_drained();

        // back to back with no idling
        idle_on = 1'b0;
        repeat (60) pending_blocks.push_back(random_block());
        wait_drained();

        idle_on = 1'b1;
        repeat (50) pending_blocks.push_back(random_block());
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d blocks (%0d fully hidden, %0d at ground level)",
                 blocks_taken, hidden_blocks, ground_blocks);
        $display("%0d vertices checked, %0d mismatches, with idle gaps, a long output stall and a back-to-back stretch",
                 verts_checked, mismatches);
        if (mismatches == 0 && expected_verts.size() == 0) begin
            $display("voxel_face_emitter_with_occlusion_test: clean");
        end else begin
            $display("voxel_face_emitter_with_occlusion_test: errors");
        end
        $finish;
    end

endmodule
